// File: hdl/raw_tile_pixel_packer_assert.svh
// ============================================================================
// Raw tile pixel packer assertion macros
// Shared assertion forms for the packer, clocked on clk and disabled in reset.
// ============================================================================
`ifndef RAW_TILE_PIXEL_PACKER_ASSERT_SVH
`define RAW_TILE_PIXEL_PACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTPP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("raw tile pixel packer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RTPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("raw tile pixel packer: next-cycle check failed");

`endif

// File: hdl/rtpp_pkg.sv
// ============================================================================
// Raw tile pixel packer package
// Payload types, register map and format codes shared by the packer.
// ============================================================================
package rtpp_pkg;

    localparam int TILE_EDGE_DEF = 64;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_PIXEL_MODE    = 2'd0;
    localparam logic [1:0] REG_VISIBLE_WIDTH = 2'd1;
    localparam logic [1:0] REG_TILE_HEIGHT   = 2'd2;

    localparam logic [1:0] MODE_BGRX   = 2'd0;
    localparam logic [1:0] MODE_BGR    = 2'd1;
    localparam logic [1:0] MODE_RGB565 = 2'd2;

    localparam logic [2:0] BYTES_BGRX   = 3'd4;
    localparam logic [2:0] BYTES_BGR    = 3'd3;
    localparam logic [2:0] BYTES_RGB565 = 3'd2;

    localparam logic [7:0] ALPHA_FILL = 8'hFF;

    localparam logic [1:0] PIXEL_MODE_RST    = MODE_BGRX;
    localparam logic [6:0] VISIBLE_WIDTH_RST = 7'd64;
    localparam logic [6:0] TILE_HEIGHT_RST   = 7'd64;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [31:0] packed_word;
        logic [2:0]  byte_count;
        logic        row_end;
        logic        tile_end;
    } result_t;

endpackage

// File: hdl/raw_tile_pixel_packer.sv
// ============================================================================
// Raw tile pixel packer
// Packs tile pixels into BGRX, BGR or RGB565 words and pads each row to a
// multiple of four pixels by repeating its last visible pixel.
// ============================================================================
// Pixels enter on the pixel channel (pixel_valid, pixel_ready, pixel) with
// rows in sending order, and packed words leave on the result channel
// (result_valid, result_ready, result). Settings are written through the APB
// port, by the user only while the block is idle; the block does not check it.
// A pixel is taken into an input register, packed by combinational logic
// and placed in the result register. One pixel per cycle is taken while
// the receiver is ready and no row end is being padded.
// The last visible pixel of a row stays in the input register until it
// has given one copy of itself and one more for each padding column, so
// the input stalls at the end of a row while the padding copies are made.
// A stalled receiver holds the result register, and the input register
// then fills and pixel_ready drops.
// Reset empties both registers, clears the column and row counters and loads
// the default settings: BGRX, 64 visible columns and 64 rows.
module raw_tile_pixel_packer #(
    parameter int TILE_EDGE = rtpp_pkg::TILE_EDGE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rtpp_pkg::CFG_AW-1:0] paddr,
    input  logic [rtpp_pkg::CFG_DW-1:0] pwdata,
    output logic [rtpp_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       pixel_valid,
    output logic                       pixel_ready,
    input  rtpp_pkg::pixel_t           pixel,
    output logic                       result_valid,
    input  logic                       result_ready,
    output rtpp_pkg::result_t          result
);

    localparam int SW   = $clog2(TILE_EDGE + 1);
    localparam int CMPW = (SW > 7) ? SW : 7;
    localparam int CNTW = $clog2(TILE_EDGE);

    logic [1:0]      pixel_mode_reg;
    logic [6:0]      visible_width_reg;
    logic [6:0]      tile_height_reg;
    logic            cfg_write;

    logic            in_valid_reg;
    rtpp_pkg::pixel_t in_pixel_reg;
    logic [1:0]      rep_reg;
    logic [1:0]      rep_next;
    logic [CNTW-1:0] column_count_reg;
    logic [CNTW-1:0] column_count_next;
    logic [CNTW-1:0] row_count_reg;
    logic [CNTW-1:0] row_count_next;
    logic            result_valid_reg;
    rtpp_pkg::result_t result_reg;
    rtpp_pkg::result_t result_next;

    logic [CMPW-1:0] width_eff;
    logic [CMPW-1:0] height_eff;
    logic [1:0]      pad;
    logic            last_visible;
    logic            last_row;
    logic            advance;
    logic            item_done;
    logic            row_done;
    logic [31:0]     word;
    logic [2:0]      count;

    function automatic logic [CMPW-1:0] clamp_size(input logic [6:0] v);
        logic [CMPW-1:0] ext;
        ext = CMPW'(v);
        if (v == 7'd0)
        begin
            return CMPW'(1);
        end
        else if (ext > CMPW'(TILE_EDGE))
        begin
            return CMPW'(TILE_EDGE);
        end
        else
        begin
            return ext;
        end
    endfunction

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg    <= rtpp_pkg::PIXEL_MODE_RST;
            visible_width_reg <= rtpp_pkg::VISIBLE_WIDTH_RST;
            tile_height_reg   <= rtpp_pkg::TILE_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                rtpp_pkg::REG_PIXEL_MODE:    pixel_mode_reg    <= pwdata[1:0];
                rtpp_pkg::REG_VISIBLE_WIDTH: visible_width_reg <= pwdata[6:0];
                rtpp_pkg::REG_TILE_HEIGHT:   tile_height_reg   <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rtpp_pkg::REG_PIXEL_MODE:    prdata = 32'(pixel_mode_reg);
            rtpp_pkg::REG_VISIBLE_WIDTH: prdata = 32'(visible_width_reg);
            rtpp_pkg::REG_TILE_HEIGHT:   prdata = 32'(tile_height_reg);
            default:                     prdata = '0;
        endcase
    end

    // Row geometry.
    assign width_eff    = clamp_size(visible_width_reg);
    assign height_eff   = clamp_size(tile_height_reg);
    assign pad          = 2'd0 - width_eff[1:0];
    assign last_visible = !((CMPW'(column_count_reg) + CMPW'(1)) < width_eff);
    assign last_row     = (CMPW'(row_count_reg) + CMPW'(1)) >= height_eff;

    // Pixel formatting.
    always_comb
    begin
        case (pixel_mode_reg)
            rtpp_pkg::MODE_BGRX:
            begin
                word  = {rtpp_pkg::ALPHA_FILL, in_pixel_reg.red,
                         in_pixel_reg.green, in_pixel_reg.blue};
                count = rtpp_pkg::BYTES_BGRX;
            end
            rtpp_pkg::MODE_BGR:
            begin
                word  = {8'd0, in_pixel_reg.red, in_pixel_reg.green, in_pixel_reg.blue};
                count = rtpp_pkg::BYTES_BGR;
            end
            default:
            begin
                word  = {16'd0, in_pixel_reg.red[7:3], in_pixel_reg.green[7:2],
                         in_pixel_reg.blue[7:3]};
                count = rtpp_pkg::BYTES_RGB565;
            end
        endcase
    end

    // Each cycle the held pixel gives one copy while the result register can load.
    assign advance     = in_valid_reg && (!result_valid_reg || result_ready);
    assign row_done    = last_visible && (rep_reg == pad);
    assign item_done   = !last_visible || (rep_reg == pad);
    assign pixel_ready = !in_valid_reg || (advance && item_done);

    always_comb
    begin
        result_next.packed_word = word;
        result_next.byte_count  = count;
        result_next.row_end     = row_done;
        result_next.tile_end    = row_done && last_row;
    end

    always_comb
    begin
        rep_next          = rep_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (advance)
        begin
            if (!last_visible)
            begin
                column_count_next = column_count_reg + CNTW'(1);
            end
            else if (row_done)
            begin
                rep_next          = 2'd0;
                column_count_next = '0;
                row_count_next    = last_row ? '0 : row_count_reg + CNTW'(1);
            end
            else
            begin
                rep_next = rep_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            rep_reg          <= 2'd0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            rep_reg          <= rep_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            if (pixel_ready)
            begin
                in_valid_reg <= pixel_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid && pixel_ready)
        begin
            in_pixel_reg <= pixel;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "raw_tile_pixel_packer_assert.svh"

    `RTPP_ASSERT_SAME(a_tile_end_on_row_end, result_valid && result.tile_end, result.row_end)
    `RTPP_ASSERT_SAME(a_rep_within_pad, in_valid_reg, rep_reg <= pad)
    `RTPP_ASSERT_SAME(a_repeat_only_last, rep_reg != 2'd0, in_valid_reg && last_visible)
    `RTPP_ASSERT_NEXT(a_copy_loads_result, advance, result_valid)

endmodule
